// ===== rtl/sensor_frame_receiver_assert.svh =====
// Assertion macros used by the frame receiver checker.
`ifndef SENSOR_FRAME_RECEIVER_ASSERT_SVH
`define SENSOR_FRAME_RECEIVER_ASSERT_SVH

// Same-cycle implication, sampled on i_clk, off during reset.
`define SFR_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on i_clk, off during reset.
`define SFR_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/sfr_pkg.sv =====
// Types, codes and the frame field layout of the sensor frame receiver.
package sfr_pkg;

    localparam logic [1:0] OP_BYTE = 2'd0;
    localparam logic [1:0] OP_END  = 2'd1;
    localparam logic [1:0] OP_POP  = 2'd2;

    typedef enum logic [2:0] {
        K_STORED    = 3'd0,
        K_DROPPED   = 3'd1,
        K_BAD       = 3'd2,
        K_POP_FIELD = 3'd3,
        K_POP_EMPTY = 3'd4
    } t_kind;

    typedef enum logic [2:0] {
        S_IDLE,
        S_WALK,
        S_FIN,
        S_EMPTY,
        S_POP_ADDR,
        S_POP_OUT
    } t_state;

    localparam int NUM_FIELDS = 11;
    localparam logic [3:0] FLD_DIST = 4'd8;
    localparam logic [3:0] FLD_CONF = 4'd9;
    localparam logic [3:0] FLD_TICK = 4'd10;

    localparam logic [7:0] HDR0 = 8'h5A;
    localparam logic [7:0] HDR1 = 8'h8E;
    localparam logic [7:0] HDR2 = 8'h17;

    localparam int         PADDR_W             = 3;
    localparam logic       REG_MAX_FRAME_BYTES = 1'b0;
    localparam logic [6:0] MAX_BYTES_RESET     = 7'd64;

    typedef struct packed {
        logic       hit;
        logic [3:0] idx;
        logic [1:0] lane;
        logic       tail;
    } t_field_pos;

    typedef struct packed {
        t_kind              kind;
        logic [6:0]         frame_length;
        logic signed [15:0] range_mm;
        logic [7:0]         confidence;
        logic               frame_ok;
        logic [31:0]        valid_count;
        logic [31:0]        bad_count;
        logic [31:0]        dropped_count;
        logic [3:0]         field_index;
        logic [31:0]        field_value;
        logic               last;
    } t_result;

    function automatic t_field_pos fp(input logic [3:0] idx, input logic [1:0] lane,
                                      input logic tail);
        t_field_pos f;
        f.hit  = 1'b1;
        f.idx  = idx;
        f.lane = lane;
        f.tail = tail;
        return f;
    endfunction

    // Byte position in the frame -> field, byte lane (little endian), last byte of field.
    function automatic t_field_pos field_map(input logic [7:0] pos);
        t_field_pos f;
        f = '0;
        case (pos)
            8'd3:    f = fp(4'd0, 2'd0, 1'b0);
            8'd4:    f = fp(4'd0, 2'd1, 1'b1);
            8'd5:    f = fp(4'd1, 2'd0, 1'b0);
            8'd6:    f = fp(4'd1, 2'd1, 1'b1);
            8'd7:    f = fp(4'd2, 2'd0, 1'b0);
            8'd8:    f = fp(4'd2, 2'd1, 1'b0);
            8'd9:    f = fp(4'd2, 2'd2, 1'b1);
            8'd10:   f = fp(4'd3, 2'd0, 1'b0);
            8'd11:   f = fp(4'd3, 2'd1, 1'b1);
            8'd12:   f = fp(4'd4, 2'd0, 1'b0);
            8'd13:   f = fp(4'd4, 2'd1, 1'b1);
            8'd14:   f = fp(4'd5, 2'd0, 1'b0);
            8'd15:   f = fp(4'd5, 2'd1, 1'b0);
            8'd16:   f = fp(4'd5, 2'd2, 1'b1);
            8'd17:   f = fp(4'd6, 2'd0, 1'b0);
            8'd18:   f = fp(4'd6, 2'd1, 1'b1);
            8'd19:   f = fp(4'd7, 2'd0, 1'b0);
            8'd20:   f = fp(4'd7, 2'd1, 1'b0);
            8'd21:   f = fp(4'd7, 2'd2, 1'b0);
            8'd22:   f = fp(4'd7, 2'd3, 1'b1);
            8'd23:   f = fp(FLD_DIST, 2'd0, 1'b0);
            8'd24:   f = fp(FLD_DIST, 2'd1, 1'b1);
            8'd25:   f = fp(FLD_CONF, 2'd0, 1'b1);
            default: f = '0;
        endcase
        return f;
    endfunction

endpackage

// ===== rtl/sfr_in_if.sv =====
// Input channel of the sensor frame receiver: one byte, end or pop event per item.
interface sfr_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  opcode;
    logic [7:0]  data;
    logic [31:0] now_ms;

    modport source (output valid, opcode, data, now_ms, input ready);
    modport sink (input valid, opcode, data, now_ms, output ready);
endinterface

// ===== rtl/sfr_out_if.sv =====
// Result channel of the sensor frame receiver.
interface sfr_out_if;
    logic               valid;
    logic               ready;
    logic [2:0]         kind;
    logic [6:0]         frame_length;
    logic signed [15:0] range_mm;
    logic [7:0]         confidence;
    logic               frame_ok;
    logic [31:0]        valid_count;
    logic [31:0]        bad_count;
    logic [31:0]        dropped_count;
    logic [3:0]         field_index;
    logic [31:0]        field_value;
    logic               last;

    modport source (
        output valid, kind, frame_length, range_mm, confidence, frame_ok,
               valid_count, bad_count, dropped_count, field_index, field_value, last,
        input  ready
    );
    modport sink (
        input  valid, kind, frame_length, range_mm, confidence, frame_ok,
               valid_count, bad_count, dropped_count, field_index, field_value, last,
        output ready
    );
endinterface

// ===== rtl/sfr_ram.sv =====
// Generic simple dual-port RAM, one write port, one registered read port.
module sfr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ===== rtl/sensor_frame_receiver.sv =====
// Sensor frame receiver: a byte item is stored (the store accepts bytes up to
// max_frame_bytes, clamped to RX_DEPTH, then only flags overflow). An end-of-frame item goes
// straight to its result when the length or overflow already fails the frame; otherwise
// the check walks the frame store through its single read port, one byte per cycle,
// summing, checking the header and writing the fields into the pending-slot RAM as they
// complete, while the slot is empty. A pop item reads the pending-slot RAM one field at a
// time through its registered read (S_POP_ADDR, then S_POP_OUT); an empty slot gives a single
// empty result. One item is worked on at a time; results sit in an output register, so a
// stalled result only holds back the next result, never a byte already waiting to be taken.
// No clearing pass: the stores are written before they are read.
module sensor_frame_receiver
    import sfr_pkg::*;
#(
    parameter int FRAME_LEN = 27,
    parameter int RX_DEPTH  = 64
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    sfr_in_if.sink             i_in,
    sfr_out_if.source          o_out,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);
    localparam int AW = $clog2(RX_DEPTH);
    localparam int CW = AW + 1;
    localparam int FW = $clog2(NUM_FIELDS);

    t_state r_state, n_state;

    logic [6:0]    r_max;
    logic [CW-1:0] r_byte_count, n_byte_count;
    logic          r_overflow, n_overflow;
    logic          r_pending_full, n_pending_full;
    logic [15:0]   r_latest_dist, n_latest_dist;
    logic [7:0]    r_latest_conf, n_latest_conf;
    logic          r_ok, n_ok;
    logic [31:0]   r_valid_total, n_valid_total;
    logic [31:0]   r_bad_total, n_bad_total;
    logic [31:0]   r_dropped_total, n_dropped_total;

    // walk control
    logic [AW-1:0] r_rd_addr, n_rd_addr;
    logic          r_issue_done, n_issue_done;
    logic          r_pvalid, n_pvalid;
    logic [AW-1:0] r_ppos, n_ppos;
    logic          r_good, n_good;
    logic [7:0]    r_sum, n_sum;
    logic [31:0]   r_acc, n_acc;
    logic [15:0]   r_cand_dist, n_cand_dist;
    logic [7:0]    r_cand_conf, n_cand_conf;
    logic [6:0]    r_flen, n_flen;
    logic [31:0]   r_now, n_now;
    logic [FW-1:0] r_fidx, n_fidx;

    logic          r_out_valid, n_out_valid;
    t_result       r_out, n_out;

    // memory ports
    logic          fs_we;
    logic [AW-1:0] fs_waddr, fs_raddr;
    logic [7:0]    fs_wdata, fs_rdata;
    logic          pf_we;
    logic [FW-1:0] pf_waddr, pf_raddr;
    logic [31:0]   pf_wdata, pf_rdata;

    logic          out_load, out_free, room;
    t_kind         out_kind;
    logic [6:0]    out_flen;
    logic [FW-1:0] out_idx;
    logic [31:0]   out_val;
    logic          out_last;
    t_field_pos    fmap;
    logic [31:0]   acc_new;
    logic          cfg_wr;

    sfr_ram #(.WIDTH(8), .DEPTH(RX_DEPTH)) u_frame_store (
        .i_clk   (i_clk),
        .i_we    (fs_we),
        .i_waddr (fs_waddr),
        .i_wdata (fs_wdata),
        .i_raddr (fs_raddr),
        .o_rdata (fs_rdata)
    );

    sfr_ram #(.WIDTH(32), .DEPTH(NUM_FIELDS)) u_pending_slot (
        .i_clk   (i_clk),
        .i_we    (pf_we),
        .i_waddr (pf_waddr),
        .i_wdata (pf_wdata),
        .i_raddr (pf_raddr),
        .o_rdata (pf_rdata)
    );

    // configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_MAX_FRAME_BYTES);
    assign prdata = (paddr[2] == REG_MAX_FRAME_BYTES) ? {25'd0, r_max} : 32'd0;

    assign room = ({25'd0, r_max} > 32'(r_byte_count)) && (32'(r_byte_count) < RX_DEPTH);
    assign out_free = !r_out_valid || o_out.ready;
    assign i_in.ready = (r_state == S_IDLE);

    always_comb begin
        n_state         = r_state;
        n_byte_count    = r_byte_count;
        n_overflow      = r_overflow;
        n_pending_full  = r_pending_full;
        n_latest_dist   = r_latest_dist;
        n_latest_conf   = r_latest_conf;
        n_ok            = r_ok;
        n_valid_total   = r_valid_total;
        n_bad_total     = r_bad_total;
        n_dropped_total = r_dropped_total;
        n_rd_addr       = r_rd_addr;
        n_issue_done    = r_issue_done;
        n_pvalid        = r_pvalid;
        n_ppos          = r_ppos;
        n_good          = r_good;
        n_sum           = r_sum;
        n_acc           = r_acc;
        n_cand_dist     = r_cand_dist;
        n_cand_conf     = r_cand_conf;
        n_flen          = r_flen;
        n_now           = r_now;
        n_fidx          = r_fidx;

        fs_we    = 1'b0;
        fs_waddr = r_byte_count[AW-1:0];
        fs_wdata = i_in.data;
        fs_raddr = r_rd_addr;

        fmap    = field_map(8'(r_ppos));
        acc_new = (fmap.lane == 2'd0) ? {24'd0, fs_rdata}
                                      : (r_acc | (32'(fs_rdata) << {fmap.lane, 3'b000}));

        pf_we    = 1'b0;
        pf_waddr = fmap.idx[FW-1:0];
        pf_wdata = (fmap.idx == FLD_DIST) ? {{16{acc_new[15]}}, acc_new[15:0]} : acc_new;
        pf_raddr = r_fidx;

        out_load = 1'b0;
        out_kind = K_POP_EMPTY;
        out_flen = 7'd0;
        out_idx  = '0;
        out_val  = 32'd0;
        out_last = 1'b1;

        case (r_state)
            S_IDLE: begin
                if (i_in.valid) begin
                    case (i_in.opcode)
                        OP_BYTE: begin
                            if (room) begin
                                fs_we        = 1'b1;
                                n_byte_count = r_byte_count + CW'(1);
                            end else begin
                                n_overflow = 1'b1;
                            end
                        end
                        OP_END: begin
                            n_flen       = 7'(r_byte_count);
                            n_good       = !r_overflow && (32'(r_byte_count) == FRAME_LEN);
                            n_now        = i_in.now_ms;
                            n_byte_count = '0;
                            n_overflow   = 1'b0;
                            n_rd_addr    = '0;
                            n_issue_done = 1'b0;
                            n_pvalid     = 1'b0;
                            n_sum        = 8'd0;
                            n_state      = n_good ? S_WALK : S_FIN;
                        end
                        OP_POP: begin
                            if (r_pending_full) begin
                                n_pending_full = 1'b0;
                                n_fidx         = '0;
                                n_state        = S_POP_ADDR;
                            end else begin
                                n_state = S_EMPTY;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end

            S_WALK: begin
                // issue side: one address per cycle, data comes back from the registered read in the next cycle
                n_pvalid = !r_issue_done;
                n_ppos   = r_rd_addr;
                if (!r_issue_done) begin
                    if (32'(r_rd_addr) == FRAME_LEN - 1) begin
                        n_issue_done = 1'b1;
                    end else begin
                        n_rd_addr = r_rd_addr + AW'(1);
                    end
                end
                if (r_pvalid) begin
                    if (32'(r_ppos) == FRAME_LEN - 1) begin
                        if (fs_rdata != r_sum) begin
                            n_good = 1'b0;
                        end
                        n_state = S_FIN;
                    end else begin
                        n_sum = r_sum + fs_rdata;
                    end
                    if ((r_ppos == AW'(0) && fs_rdata != HDR0) ||
                        (r_ppos == AW'(1) && fs_rdata != HDR1) ||
                        (r_ppos == AW'(2) && fs_rdata != HDR2)) begin
                        n_good = 1'b0;
                    end
                    if (fmap.hit) begin
                        n_acc = acc_new;
                        // fields land in the slot as they finish, unless it is full; harmless if the frame fails
                        if (fmap.tail) begin
                            pf_we = !r_pending_full;
                        end
                        if (fmap.tail && fmap.idx == FLD_DIST) begin
                            n_cand_dist = acc_new[15:0];
                        end
                        if (fmap.idx == FLD_CONF) begin
                            n_cand_conf = fs_rdata;
                        end
                    end
                end
            end

            S_FIN: begin
                if (out_free) begin
                    if (r_good) begin
                        n_latest_dist = r_cand_dist;
                        n_latest_conf = r_cand_conf;
                        n_ok          = 1'b1;
                        n_valid_total = r_valid_total + 32'd1;
                        if (!r_pending_full) begin
                            pf_we          = 1'b1;
                            pf_waddr       = FLD_TICK[FW-1:0];
                            pf_wdata       = r_now;
                            n_pending_full = 1'b1;
                            out_kind       = K_STORED;
                        end else begin
                            n_dropped_total = r_dropped_total + 32'd1;
                            out_kind        = K_DROPPED;
                        end
                    end else begin
                        n_ok        = 1'b0;
                        n_bad_total = r_bad_total + 32'd1;
                        out_kind    = K_BAD;
                    end
                    out_flen = r_flen;
                    out_load = 1'b1;
                    n_state  = S_IDLE;
                end
            end

            S_EMPTY: begin
                if (out_free) begin
                    out_kind = K_POP_EMPTY;
                    out_load = 1'b1;
                    n_state  = S_IDLE;
                end
            end

            S_POP_ADDR: begin
                n_state = S_POP_OUT;
            end

            S_POP_OUT: begin
                if (out_free) begin
                    out_kind = K_POP_FIELD;
                    out_idx  = r_fidx;
                    out_val  = pf_rdata;
                    out_last = (r_fidx == FLD_TICK[FW-1:0]);
                    out_load = 1'b1;
                    if (out_last) begin
                        n_state = S_IDLE;
                    end else begin
                        n_fidx  = r_fidx + FW'(1);
                        n_state = S_POP_ADDR;
                    end
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase

        n_out.kind          = out_kind;
        n_out.frame_length  = out_flen;
        n_out.range_mm      = n_latest_dist;
        n_out.confidence    = n_latest_conf;
        n_out.frame_ok      = n_ok;
        n_out.valid_count   = n_valid_total;
        n_out.bad_count     = n_bad_total;
        n_out.dropped_count = n_dropped_total;
        n_out.field_index   = 4'(out_idx);
        n_out.field_value   = out_val;
        n_out.last          = out_last;

        n_out_valid = out_load ? 1'b1 : (o_out.ready ? 1'b0 : r_out_valid);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max           <= MAX_BYTES_RESET;
            r_byte_count    <= '0;
            r_overflow      <= 1'b0;
            r_pending_full  <= 1'b0;
            r_latest_dist   <= 16'd0;
            r_latest_conf   <= 8'd0;
            r_ok            <= 1'b0;
            r_valid_total   <= 32'd0;
            r_bad_total     <= 32'd0;
            r_dropped_total <= 32'd0;
            r_rd_addr       <= '0;
            r_issue_done    <= 1'b0;
            r_pvalid        <= 1'b0;
            r_fidx          <= '0;
            r_out_valid     <= 1'b0;
        end else begin
            if (cfg_wr) begin
                r_max <= pwdata[6:0];
            end
            r_byte_count    <= n_byte_count;
            r_overflow      <= n_overflow;
            r_pending_full  <= n_pending_full;
            r_latest_dist   <= n_latest_dist;
            r_latest_conf   <= n_latest_conf;
            r_ok            <= n_ok;
            r_valid_total   <= n_valid_total;
            r_bad_total     <= n_bad_total;
            r_dropped_total <= n_dropped_total;
            r_rd_addr       <= n_rd_addr;
            r_issue_done    <= n_issue_done;
            r_pvalid        <= n_pvalid;
            r_fidx          <= n_fidx;
            r_out_valid     <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ppos      <= n_ppos;
        r_good      <= n_good;
        r_sum       <= n_sum;
        r_acc       <= n_acc;
        r_cand_dist <= n_cand_dist;
        r_cand_conf <= n_cand_conf;
        r_flen      <= n_flen;
        r_now       <= n_now;
        if (out_load) begin
            r_out <= n_out;
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.kind          = r_out.kind;
    assign o_out.frame_length  = r_out.frame_length;
    assign o_out.range_mm      = r_out.range_mm;
    assign o_out.confidence    = r_out.confidence;
    assign o_out.frame_ok      = r_out.frame_ok;
    assign o_out.valid_count   = r_out.valid_count;
    assign o_out.bad_count     = r_out.bad_count;
    assign o_out.dropped_count = r_out.dropped_count;
    assign o_out.field_index   = r_out.field_index;
    assign o_out.field_value   = r_out.field_value;
    assign o_out.last          = r_out.last;
endmodule

// ===== rtl/sfr_checker.sv =====
// Port-level checker for the sensor frame receiver, bound to the top level.
`include "sensor_frame_receiver_assert.svh"

module sfr_checker
    import sfr_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [2:0]  i_kind,
    input logic [3:0]  i_field_index,
    input logic [31:0] i_field_value,
    input logic        i_last
);
    `SFR_ASSERT_NEXT(a_out_hold, i_out_valid && !i_out_ready, i_out_valid && $stable(i_kind) && $stable(i_field_value) && $stable(i_last), "stalled result changed")

    `SFR_ASSERT_NOW(a_kind_legal, i_out_valid, i_kind == K_STORED || i_kind == K_DROPPED || i_kind == K_BAD || i_kind == K_POP_FIELD || i_kind == K_POP_EMPTY, "illegal result kind")

    `SFR_ASSERT_NOW(a_single_result, i_out_valid && i_kind != K_POP_FIELD, i_last && i_field_index == 4'd0 && i_field_value == 32'd0, "end or empty result malformed")

    `SFR_ASSERT_NOW(a_pop_last, i_out_valid && i_kind == K_POP_FIELD, i_last == (i_field_index == FLD_TICK), "pop run ends on wrong field")

    // while a pop run is still showing a non-final field, no new item is taken
    `SFR_ASSERT_NOW(a_pop_busy, i_out_valid && i_kind == K_POP_FIELD && !i_last, !i_in_ready, "new item taken during pop run")
endmodule

bind sensor_frame_receiver sfr_checker u_sfr_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_ready    (i_in.ready),
    .i_out_valid   (o_out.valid),
    .i_out_ready   (o_out.ready),
    .i_kind        (o_out.kind),
    .i_field_index (o_out.field_index),
    .i_field_value (o_out.field_value),
    .i_last        (o_out.last)
);
